### design/deq_pkg.sv
// Shared types for the double-ended queue: request and status codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package deq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_LIST       = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;     // act on the request beat now being accepted
		logic fetch;    // registered store data is valid, load it into the result
		logic advance;  // list walk: step to the next entry and read it
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic more;     // a list walk has entries still to send
	} sts_t;

endpackage

### design/deq_req_if.sv
// Request channel: valid/ready handshake carrying request code and push value.
// Depends on nothing.
interface deq_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] value_in;

	modport source (output valid, output req_type, output value_in, input ready);
	modport sink   (input valid, input req_type, input value_in, output ready);
endinterface

### design/deq_rsp_if.sv
// Result channel: valid/ready handshake carrying status, value, count and last mark.
// CNT_W sizes the entry count field.
interface deq_rsp_if #(
	parameter int CNT_W = 5
);
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] value_out;
	logic [CNT_W-1:0]   entry_count;
	logic               last;

	modport source (output valid, output status, output value_out, output entry_count,
		output last, input ready);
	modport sink   (input valid, input status, input value_out, input entry_count,
		input last, output ready);
endinterface

### design/deq_ctrl.sv
// Sequencing controller for the queue: takes request beats, waits for store reads,
// holds each result beat until taken. Uses deq_pkg.
module deq_ctrl import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] req_type,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.exec = 1'b1;
					unique case (req_type)
						REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_CLEAR: state_d = S_OUT;
						REQ_POP_FRONT, REQ_POP_BACK, REQ_LIST:
							state_d = sts.empty ? S_OUT : S_RD;
						default: state_d = S_IDLE; // unused codes are dropped
					endcase
				end
			end
			S_RD: begin
				cmd.fetch = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.more) begin
						cmd.advance = 1'b1;
						state_d     = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request accepted while a result beat is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> out_valid)
		else $error("store read not followed by a result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result beat withdrawn under stall");

endmodule

### design/deq_dpath.sv
// Datapath for the queue: ring store, front index, occupancy, list walk index and
// the result register. Uses deq_pkg; driven by deq_ctrl commands.
module deq_dpath import deq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value_in,
	output logic [1:0]         status,
	output logic signed [31:0] value_out,
	output logic [CNT_W-1:0]   entry_count,
	output logic               last
);

	logic [31:0]      mem [DEPTH];
	logic [31:0]      rdata_q;

	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             list_q, list_d;
	status_t          st_q, st_d;
	logic             last_q, last_d;
	logic [31:0]      value_q, value_d;

	logic             we, re;
	logic [IDX_W-1:0] waddr, raddr, front_dec;
	logic             empty, full, walk_last;

	// front + offset, folded back into the ring
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH)) s = s - (IDX_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign walk_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		k_d     = k_q;
		list_d  = list_q;
		st_d    = st_q;
		last_d  = last_q;
		value_d = value_q;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = front_q;
		raddr   = front_q;
		if (cmd.exec) begin
			list_d  = 1'b0;
			last_d  = 1'b1;
			value_d = '0;
			st_d    = ST_OK;
			case (req_type)
				REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + CNT_W'(1);
						if (req_type == REQ_PUSH_FRONT) begin
							waddr   = front_dec;
							front_d = front_dec;
						end else begin
							waddr = ring_pos(front_q, count_q[IDX_W-1:0]);
						end
					end
				end
				REQ_POP_FRONT, REQ_POP_BACK: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						re      = 1'b1;
						count_d = count_q - CNT_W'(1);
						if (req_type == REQ_POP_FRONT) begin
							raddr   = front_q;
							front_d = ring_pos(front_q, IDX_W'(1));
						end else begin
							raddr = ring_pos(front_q, count_d[IDX_W-1:0]);
						end
						// an emptied ring restarts at position zero
						if (count_d == '0) front_d = '0;
					end
				end
				REQ_LIST: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						re     = 1'b1;
						raddr  = front_q;
						k_d    = '0;
						list_d = 1'b1;
					end
				end
				REQ_CLEAR: begin
					front_d = '0;
					count_d = '0;
				end
				default: begin
					// unused code: leave the result register as it was
					list_d  = list_q;
					last_d  = last_q;
					value_d = value_q;
					st_d    = st_q;
				end
			endcase
		end
		if (cmd.fetch) begin
			value_d = rdata_q;
			last_d  = !list_q || walk_last;
		end
		if (cmd.advance) begin
			k_d   = k_q + IDX_W'(1);
			re    = 1'b1;
			raddr = ring_pos(front_q, k_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			list_q  <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			list_q  <= list_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		st_q    <= st_d;
		last_q  <= last_d;
		value_q <= value_d;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= value_in;
		if (re) rdata_q <= mem[raddr];
	end

	assign sts.empty   = empty;
	assign sts.more    = list_q && !last_q;
	assign status      = st_q;
	assign value_out   = value_q;
	assign entry_count = count_q;
	assign last        = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond ring depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (front_q == '0))
		else $error("empty ring with front index off zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (list_q && !last_q && !cmd.exec))
		else $error("list walk stepped outside a list request");

endmodule

### design/double_ended_queue.sv
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ctrl and deq_dpath.
//
//  channel | dir | fields                                  | beat
//  req     | in  | req_type[2:0], value_in[31:0]           | valid && ready
//  rsp     | out | status[1:0], value_out[31:0],           | valid && ready
//          |     | entry_count[CNT_W-1:0], last            |
//
// Push and clear: result beat from the cycle after acceptance.
// Pop: one registered store read before its result beat; a pop or list on an empty
// queue reads nothing and its beat comes in the cycle after acceptance. List: each
// entry is one store read then one result beat, and the next entry is read only
// after the sink takes the beat; the store's single read port sets the pace.
// Reset clears front index and occupancy at once; the store is not cleared.
// A stalled result holds the block: no request is taken until it is delivered.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	deq_req_if.sink          req,
	deq_rsp_if.source        rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t cmd;
	sts_t sts;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.value_in    (req.value_in),
		.status      (rsp.status),
		.value_out   (rsp.value_out),
		.entry_count (rsp.entry_count),
		.last        (rsp.last)
	);

endmodule

### tb/sv/deq_result_check.sv
// Watches the request and result channels of the double-ended queue, keeps its own
// copy of the ring and compares every result beat with the oldest predicted one.
// Depends on deq_pkg, deq_req_if and deq_rsp_if.
module deq_result_check import deq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	deq_req_if   req,
	deq_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding
);

	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic [CNT_W-1:0]   count;
		logic               last;
	} deq_result_t;

	logic signed [31:0] ring [DEPTH];
	int unsigned        head = 0;
	int unsigned        fill = 0;
	deq_result_t        predicted_q[$];

	function automatic int unsigned slot(input int unsigned offset);
		return (head + offset) % DEPTH;
	endfunction

	function automatic void queue_result(input status_t st, input logic signed [31:0] v,
		input int unsigned n, input logic lst);
		deq_result_t r;
		r.status = st;
		r.value  = v;
		r.count  = CNT_W'(n);
		r.last   = lst;
		predicted_q.push_back(r);
	endfunction

	// apply one accepted request beat to the shadow ring
	task automatic apply_request(input logic [2:0] code, input logic signed [31:0] value);
		logic signed [31:0] v;
		int unsigned        k;
		case (code)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					queue_result(ST_FULL, '0, fill, 1'b1);
				end else begin
					if (code == REQ_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						ring[head] = value;
					end else begin
						ring[slot(fill)] = value;
					end
					fill++;
					queue_result(ST_OK, '0, fill, 1'b1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (fill == 0) begin
					queue_result(ST_EMPTY, '0, 0, 1'b1);
				end else begin
					if (code == REQ_POP_FRONT) begin
						v = ring[head];
						head = slot(1);
					end else begin
						v = ring[slot(fill - 1)];
					end
					fill--;
					if (fill == 0) head = 0;
					queue_result(ST_OK, v, fill, 1'b1);
				end
			end
			REQ_LIST: begin
				if (fill == 0) begin
					queue_result(ST_EMPTY, '0, 0, 1'b1);
				end else begin
					for (k = 0; k < fill; k++)
						queue_result(ST_OK, ring[slot(k)], fill, (k + 1 == fill));
				end
			end
			REQ_CLEAR: begin
				head = 0;
				fill = 0;
				queue_result(ST_OK, '0, 0, 1'b1);
			end
			default: ; // unused codes leave everything as it is
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		deq_result_t want;
		if (!arst_n) begin
			head = 0;
			fill = 0;
			predicted_q.delete();
			outstanding = 0;
		end else begin
			// result beats first: a result can never belong to a request taken at this edge
			if (rsp.valid && rsp.ready) begin
				if (predicted_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat: expected none, got status %0d",
						$time, rsp.status);
					$display("  value %0d count %0d last %0d",
						rsp.value_out, rsp.entry_count, rsp.last);
				end else begin
					want = predicted_q.pop_front();
					if (rsp.status !== want.status || rsp.value_out !== want.value ||
						rsp.entry_count !== want.count || rsp.last !== want.last) begin
						fail_count++;
						$display("%0t: result mismatch: expected status %0d value %0d",
							$time, want.status, want.value);
						$display("  count %0d last %0d, got status %0d value %0d",
							want.count, want.last, rsp.status, rsp.value_out);
						$display("  count %0d last %0d", rsp.entry_count, rsp.last);
					end
				end
			end
			if (req.valid && req.ready)
				apply_request(req.req_type, req.value_in);
			outstanding = predicted_q.size();
		end
	end

endmodule

### tb/sv/tb.sv
// Top of the double-ended queue testbench: clock, reset, request stimulus and result
// back-pressure; the verdict comes from the failure count of deq_result_check.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, double_ended_queue and deq_result_check.
module tb;
	import deq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CNT_W = 5;
	localparam int TOTAL_ITEMS = 160;

	// codes the block must ignore
	localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

	// idle modes: none, full range, short gaps
	localparam int GAP_NONE  = 0;
	localparam int GAP_WIDE  = 1;
	localparam int GAP_SHORT = 2;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   src_mode  = GAP_WIDE;
	int   sink_mode = GAP_WIDE;
	int   items_sent = 0;

	deq_req_if req_ch ();
	deq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

	double_ended_queue #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_result_check #(.DEPTH(DEPTH), .CNT_W(CNT_W)) result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	function automatic int draw_gap(input int mode);
		case (mode)
			GAP_NONE:  return 0;
			GAP_SHORT: return $urandom_range(0, 3);
			default:   return $urandom_range(0, 12);
		endcase
	endfunction

	function automatic logic signed [31:0] draw_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// entered and left at a falling edge; valid stays high between back-to-back beats
	task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
		int gap;
		gap = draw_gap(src_mode);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= code;
		req_ch.value_in <= value;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (code != REQ_UNUSED_6 && code != REQ_UNUSED_7) items_sent++;
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic send_mixed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22)      send_request(REQ_PUSH_FRONT, draw_value());
		else if (r < 44) send_request(REQ_PUSH_BACK, draw_value());
		else if (r < 62) send_request(REQ_POP_FRONT, $urandom);
		else if (r < 80) send_request(REQ_POP_BACK, $urandom);
		else if (r < 90) send_request(REQ_LIST, $urandom);
		else if (r < 94) send_request(REQ_CLEAR, $urandom);
		else if (r < 97) send_request(REQ_UNUSED_6, $urandom);
		else             send_request(REQ_UNUSED_7, $urandom);
	endtask

	// result side: ready drops for a drawn number of cycles before each beat
	initial begin
		int gap;
		int beats;
		rsp_ch.ready <= 1'b0;
		beats = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 23) == 0) sink_mode = $urandom_range(GAP_NONE, GAP_SHORT);
			gap = draw_gap(sink_mode);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			beats++;
		end
	end

	initial begin
		int seg;
		int n;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_PUSH_FRONT;
		req_ch.value_in <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty cases, extremes, both ends, ignored codes
		src_mode = GAP_SHORT;
		send_request(REQ_LIST, 32'sd0);
		send_request(REQ_POP_FRONT, 32'sd0);
		send_request(REQ_POP_BACK, -32'sd1);
		send_request(REQ_CLEAR, 32'sd0);
		send_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
		send_request(REQ_PUSH_BACK, 32'sh8000_0000);
		send_request(REQ_PUSH_FRONT, 32'sd0);
		send_request(REQ_PUSH_BACK, -32'sd1);
		send_request(REQ_UNUSED_6, 32'sh5555_5555);
		send_request(REQ_UNUSED_7, 32'shaaaa_aaaa);
		send_request(REQ_LIST, 32'sd0);
		send_request(REQ_POP_FRONT, 32'sd0);
		send_request(REQ_POP_BACK, 32'sd0);
		send_request(REQ_LIST, 32'sd0);
		send_request(REQ_POP_BACK, 32'sd0);
		send_request(REQ_POP_FRONT, 32'sd0);
		send_request(REQ_POP_FRONT, 32'sd0);
		send_request(REQ_PUSH_BACK, 32'sh1234_5678);
		send_request(REQ_CLEAR, 32'sd0);
		send_request(REQ_LIST, 32'sd0);
		hold_until_drained();

		// random: fill to overflow, drain past empty, mixed runs, clear and refill
		seg = 0;
		while (items_sent < TOTAL_ITEMS) begin
			src_mode = $urandom_range(GAP_NONE, GAP_SHORT);
			case ($urandom_range(0, 5))
				0, 1: begin
					n = DEPTH + $urandom_range(1, 3);
					repeat (n)
						send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
							draw_value());
					send_request(REQ_LIST, $urandom);
				end
				2: begin
					n = DEPTH + $urandom_range(1, 3);
					repeat (n)
						send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
							$urandom);
					send_request(REQ_LIST, $urandom);
				end
				3: begin
					send_request(REQ_CLEAR, $urandom);
					repeat ($urandom_range(1, 6))
						send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
							draw_value());
				end
				default: begin
					repeat ($urandom_range(8, 24)) send_mixed();
				end
			endcase
			seg++;
			if (seg % 4 == 0) hold_until_drained();
		end

		hold_until_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule

### files.f
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue.sv
tb/sv/deq_result_check.sv
tb/sv/tb.sv
